// File: rtl/core/plist_pkg.sv
// plist_pkg: shared types, codes and defaults for the positional list engine.
// No dependencies; every other file of the block except plist_ram imports it.
package plist_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // command queue between front and back (depth is a power of two)
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // result queue (depth is a power of two)
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_LW    = $clog2(OUTQ_DEPTH + 1);

  // request function codes
  localparam logic [2:0] FN_INS_FRONT = 3'd0;
  localparam logic [2:0] FN_INS_BACK  = 3'd1;
  localparam logic [2:0] FN_INS_POS   = 3'd2;
  localparam logic [2:0] FN_READ      = 3'd3;
  localparam logic [2:0] FN_DEL_FRONT = 3'd4;
  localparam logic [2:0] FN_DEL_BACK  = 3'd5;
  localparam logic [2:0] FN_DEL_POS   = 3'd6;
  localparam logic [2:0] FN_UNUSED    = 3'd7;

  // classified operations handed to the back end
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_POS   = 3'd2;
  localparam logic [2:0] OP_READ      = 3'd3;
  localparam logic [2:0] OP_DEL_FRONT = 3'd4;
  localparam logic [2:0] OP_DEL_BACK  = 3'd5;
  localparam logic [2:0] OP_DEL_POS   = 3'd6;
  localparam logic [2:0] OP_BADPOS    = 3'd7;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic [5:0]         position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               final_flag;
  } res_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         position;
    logic signed [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    res_t data;
  } res_push_t;

endpackage

// File: rtl/core/positional_list_engine.sv
// positional_list_engine: top level of the bounded ordered list of signed words.
// Depends on plist_pkg, plist_front, plist_outq, plist_back (and plist_ram).
//
//  channel   handshake       payload   beat accepted when
//  --------  --------------  --------  --------------------------
//  request   push / full     req_t     push && !full
//  result    empty / pop     res_t     pop && !empty
//
// Front/back inserts and deletes are done by the back end straight from its
// idle state once taken from the command queue. Positional ops shift the words
// through the RAM's one write and one read port. A read streams one element per cycle while the
// result queue drains. Reset (rst, synchronous) clears the count, head pointer,
// back-end state and queues; the element RAM is left as is. A held pop stalls
// the back end once the result queue fills; full then backs up the request side.
module positional_list_engine import plist_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t request,
  output logic empty,
  input  logic pop,
  output res_t result
);

  // front -> back command handoff
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_take;

  // back -> result queue
  res_push_t          res_push;
  logic [OUTQ_LW-1:0] level;

  // classify beats; function code 7 is dropped here with no result
  plist_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  // list state lives here: head pointer, count, and the element RAM
  plist_back #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .level    (level),
    .res_push (res_push)
  );

  // results wait here until popped
  plist_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .res_push(res_push),
    .pop     (pop),
    .empty   (empty),
    .result  (result),
    .level   (level)
  );

endmodule

// File: rtl/core/plist_ram.sv
// plist_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module plist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/plist_front.sv
// plist_front: accepts request beats, classifies them and queues commands.
// Depends on plist_pkg.
module plist_front import plist_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t request,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_take
);

  cmd_t               q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp;
  logic [CMDQ_AW-1:0] rp;
  logic [CMDQ_CW-1:0] cnt;
  cmd_t               cls;
  logic               keep;
  logic               enq;
  logic               deq;

  // for positional ops, position 1 folds into the front ops, position 0 is always bad
  always_comb begin
    cls.position   = request.position;
    cls.item_value = request.item_value;
    cls.op         = OP_BADPOS;
    keep           = 1'b1;
    unique case (request.func)
      FN_INS_FRONT: cls.op = OP_INS_FRONT;
      FN_INS_BACK:  cls.op = OP_INS_BACK;
      FN_INS_POS: begin
        if (request.position == 6'd0) cls.op = OP_BADPOS;
        else if (request.position == 6'd1) cls.op = OP_INS_FRONT;
        else cls.op = OP_INS_POS;
      end
      FN_READ:      cls.op = OP_READ;
      FN_DEL_FRONT: cls.op = OP_DEL_FRONT;
      FN_DEL_BACK:  cls.op = OP_DEL_BACK;
      FN_DEL_POS: begin
        if (request.position == 6'd0) cls.op = OP_BADPOS;
        else if (request.position == 6'd1) cls.op = OP_DEL_FRONT;
        else cls.op = OP_DEL_POS;
      end
      FN_UNUSED:    keep = 1'b0;
      default:      keep = 1'b0;
    endcase
  end

  assign full      = (cnt == CMDQ_CW'(CMDQ_DEPTH));
  assign enq       = push && !full && keep;
  assign cmd_valid = (cnt != '0);
  assign deq       = cmd_take && cmd_valid;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (enq) wp <= wp + CMDQ_AW'(1);
      if (deq) rp <= rp + CMDQ_AW'(1);
      if (enq && !deq) cnt <= cnt + CMDQ_CW'(1);
      else if (deq && !enq) cnt <= cnt - CMDQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) q[wp] <= cls;
  end

endmodule

// File: rtl/core/plist_outq.sv
// plist_outq: result queue that decouples the back end from the consumer.
// Depends on plist_pkg.
module plist_outq import plist_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  res_push_t          res_push,
  input  logic               pop,
  output logic               empty,
  output res_t               result,
  output logic [OUTQ_LW-1:0] level
);

  res_t               q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wp;
  logic [OUTQ_AW-1:0] rp;
  logic               deq;

  // back end only pushes when it has checked for room
  assign empty  = (level == '0);
  assign deq    = pop && !empty;
  assign result = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (res_push.valid) wp <= wp + OUTQ_AW'(1);
      if (deq) rp <= rp + OUTQ_AW'(1);
      if (res_push.valid && !deq) level <= level + OUTQ_LW'(1);
      else if (deq && !res_push.valid) level <= level - OUTQ_LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push.valid) q[wp] <= res_push.data;
  end

endmodule

// File: rtl/core/plist_back.sv
// plist_back: executes list commands on a circular buffer held in plist_ram.
// Depends on plist_pkg and plist_ram.
module plist_back import plist_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_take,
  input  logic [OUTQ_LW-1:0] level,
  output res_push_t          res_push
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  // logical index -> physical address, offset from head with one wrap
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(l);
    if (s >= SW'(CAPACITY)) s = s - SW'(CAPACITY);
    return s[AW-1:0];
  endfunction

  logic [1:0]            state, state_next;
  logic [AW-1:0]         head, head_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         left, left_next;
  logic                  pend, pend_next;
  logic [CW-1:0]         cur, cur_next;
  logic [CW-1:0]         pend_tgt, pend_tgt_next;
  logic                  pend_last, pend_last_next;
  logic                  shift_ins, shift_ins_next;
  logic [CW-1:0]         slot, slot_next;
  logic [DATA_WIDTH-1:0] word, word_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic signed [31:0]         in_val;
  logic signed [63:0]         in_wide;
  logic [DATA_WIDTH-1:0]      word_w;
  logic signed [DATA_WIDTH-1:0] rd_s;
  logic signed [63:0]         rd_wide;
  logic [CMPW-1:0]            pos_x;
  logic [CMPW-1:0]            cnt_x;
  logic [CW-1:0]              slot_c;
  logic [AW-1:0]              head_dec;
  logic [AW-1:0]              head_inc;
  logic                       is_full;
  logic [OUTQ_LW:0]           credit;

  plist_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    in_val   = cmd.item_value;
    in_wide  = 64'(in_val);
    word_w   = in_wide[DATA_WIDTH-1:0];
    rd_s     = rdata;
    rd_wide  = 64'(rd_s);
    pos_x    = CMPW'(cmd.position);
    cnt_x    = CMPW'(count);
    slot_c   = CW'(pos_x - CMPW'(1));
    head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
    head_inc = (head == AW'(CAPACITY - 1)) ? '0 : head + AW'(1);
    is_full  = (count == CAP_C);
    credit   = (OUTQ_LW + 1)'(level) + (OUTQ_LW + 1)'(pend);
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    left_next      = left;
    pend_next      = pend;
    cur_next       = cur;
    pend_tgt_next  = pend_tgt;
    pend_last_next = pend_last;
    shift_ins_next = shift_ins;
    slot_next      = slot;
    word_next      = word;
    we             = 1'b0;
    waddr          = phys(head, count);
    wdata          = word_w;
    raddr          = phys(head, cur);
    cmd_take       = 1'b0;
    res_push.valid           = 1'b0;
    res_push.data.status     = ST_OK;
    res_push.data.read_value = '0;
    res_push.data.final_flag = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && (level < OUTQ_LW'(OUTQ_DEPTH))) begin
          cmd_take       = 1'b1;
          res_push.valid = 1'b1;
          unique case (cmd.op)
            OP_INS_FRONT: begin
              if (is_full) begin
                res_push.data.status = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = head_dec;
                head_next  = head_dec;
                count_next = count + CW'(1);
              end
            end
            OP_INS_BACK: begin
              if (is_full) begin
                res_push.data.status = ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_INS_POS: begin
              if (pos_x > cnt_x + CMPW'(1)) begin
                res_push.data.status = ST_BADPOS;
              end else if (is_full) begin
                res_push.data.status = ST_FULL;
              end else if (pos_x == cnt_x + CMPW'(1)) begin
                we         = 1'b1;
                count_next = count + CW'(1);
              end else begin
                res_push.valid = 1'b0;
                state_next     = S_SHIFT;
                shift_ins_next = 1'b1;
                cur_next       = count - CW'(1);
                left_next      = count - slot_c;
                slot_next      = slot_c;
                word_next      = word_w;
              end
            end
            OP_READ: begin
              if (count == '0) begin
                res_push.data.status = ST_EMPTY;
              end else begin
                res_push.valid = 1'b0;
                state_next     = S_READ;
                cur_next       = '0;
                left_next      = count;
              end
            end
            OP_DEL_FRONT: begin
              if (count == '0) begin
                res_push.data.status = ST_EMPTY;
              end else begin
                head_next  = head_inc;
                count_next = count - CW'(1);
              end
            end
            OP_DEL_BACK: begin
              if (count == '0) begin
                res_push.data.status = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            OP_DEL_POS: begin
              if (pos_x > cnt_x) begin
                res_push.data.status = ST_BADPOS;
              end else if (pos_x == cnt_x) begin
                count_next = count - CW'(1);
              end else begin
                res_push.valid = 1'b0;
                state_next     = S_SHIFT;
                shift_ins_next = 1'b0;
                cur_next       = CW'(pos_x);
                left_next      = count - CW'(pos_x);
              end
            end
            OP_BADPOS: res_push.data.status = ST_BADPOS;
            default:   res_push.data.status = ST_BADPOS;
          endcase
        end
      end

      S_SHIFT: begin
        // read one word per cycle, write it one slot over the next cycle
        if (pend) begin
          we    = 1'b1;
          waddr = phys(head, pend_tgt);
          wdata = rdata;
        end
        if (left != '0) begin
          pend_next     = 1'b1;
          pend_tgt_next = shift_ins ? cur + CW'(1) : cur - CW'(1);
          cur_next      = shift_ins ? cur - CW'(1) : cur + CW'(1);
          left_next     = left - CW'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            if (shift_ins) begin
              we         = 1'b1;
              waddr      = phys(head, slot);
              wdata      = word;
              count_next = count + CW'(1);
            end else begin
              count_next = count - CW'(1);
            end
            res_push.valid = 1'b1;
            state_next     = S_IDLE;
          end
        end
      end

      S_READ: begin
        if (pend) begin
          res_push.valid           = 1'b1;
          res_push.data.read_value = rd_wide[31:0];
          res_push.data.final_flag = pend_last;
        end
        // issue only while the result queue can absorb the word in flight
        if ((left != '0) && (credit < (OUTQ_LW + 1)'(OUTQ_DEPTH))) begin
          pend_next      = 1'b1;
          pend_last_next = (left == CW'(1));
          cur_next       = cur + CW'(1);
          left_next      = left - CW'(1);
        end else begin
          pend_next = 1'b0;
        end
        if (left == '0) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      left  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      left  <= left_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    pend_tgt  <= pend_tgt_next;
    pend_last <= pend_last_next;
    shift_ins <= shift_ins_next;
    slot      <= slot_next;
    word      <= word_next;
  end

endmodule

// File: test/tb_positional_list_engine.sv
`timescale 1ns / 100ps
// tb_positional_list_engine: self-checking bench for the positional list engine.
// Needs plist_pkg and the positional_list_engine RTL. A shadow list predicts
// every result beat, and directed and random requests run under varied idling.
module tb_positional_list_engine import plist_pkg::*; ();

  // Cycles with no beat on either side before the run is called hung. The
  // longest legal quiet stretch is the receiver hold-off plus one full shift.
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 200;
  // Quiet tail after the last result; covers the slowest positional shift.
  localparam int TAIL_CYCLES  = 100;
  localparam int ITEMS_PER_PH = 103;
  localparam int MAX_REPORTS  = 40;

  // Shadow copy of the list plus the queue of result beats still owed by the
  // block. note_request runs on every accepted request beat, check_result on
  // every accepted result beat.
  class list_shadow;
    logic signed [31:0] words[$];
    res_t               owed_results[$];
    int                 errors;

    function new();
      errors = 0;
    endfunction

    function int word_count();
      return words.size();
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    function void owe(logic [1:0] status, logic signed [31:0] value, logic last);
      res_t r;
      r.status     = status;
      r.read_value = value;
      r.final_flag = last;
      owed_results.push_back(r);
    endfunction

    // Insert so the word lands at 0-based slot; a full list refuses.
    function logic [1:0] place(int slot, logic signed [31:0] value);
      if (words.size() >= CAPACITY_DEF) return ST_FULL;
      words.insert(slot, value);
      return ST_OK;
    endfunction

    function void note_request(req_t r);
      int n;
      n = words.size();
      // DATA_WIDTH equals the item width, so words are stored as given.
      case (r.func) inside
        FN_INS_FRONT: owe(place(0, r.item_value), '0, 1'b1);
        FN_INS_BACK:  owe(place(n, r.item_value), '0, 1'b1);
        FN_INS_POS: begin
          // position 1 and n+1 are plain front and back inserts
          if (r.position >= 1 && r.position <= n + 1)
            owe(place(r.position - 1, r.item_value), '0, 1'b1);
          else
            owe(ST_BADPOS, '0, 1'b1);
        end
        FN_READ: begin
          if (n == 0) owe(ST_EMPTY, '0, 1'b1);
          for (int i = 0; i < n; i++) owe(ST_OK, words[i], i == n - 1);
        end
        FN_DEL_FRONT, FN_DEL_BACK: begin
          if (n == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            words.delete((r.func == FN_DEL_FRONT) ? 0 : n - 1);
            owe(ST_OK, '0, 1'b1);
          end
        end
        FN_DEL_POS: begin
          // position 1 behaves as delete front, empty list included
          if (r.position == 1 && n == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else if (r.position >= 1 && r.position <= n) begin
            words.delete(r.position - 1);
            owe(ST_OK, '0, 1'b1);
          end else begin
            owe(ST_BADPOS, '0, 1'b1);
          end
        end
        default: ;  // unused code: no beat, no change
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        flag($sformatf("result beat with none expected: status %0d value %0d final %0b",
                       got.status, got.read_value, got.final_flag));
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status)
        flag($sformatf("status mismatch: expected %0d, actual %0d",
                       want.status, got.status));
      if (got.read_value !== want.read_value)
        flag($sformatf("read_value mismatch: expected %0d, actual %0d",
                       want.read_value, got.read_value));
      if (got.final_flag !== want.final_flag)
        flag($sformatf("final_flag mismatch: expected %0b, actual %0b",
                       want.final_flag, got.final_flag));
    endfunction
  endclass

  logic clk     = 1'b0;
  logic rst     = 1'b1;
  logic push    = 1'b0;
  logic pop     = 1'b0;
  req_t request = '0;
  logic full;
  logic empty;
  res_t result;

  list_shadow shadow = new();

  // idling knobs, percent of cycles; changed only while the block is drained
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // raised by the main sequence, picked up and cleared by the result sink
  bit hold_request   = 1'b0;

  positional_list_engine #(
    .CAPACITY   (CAPACITY_DEF),
    .DATA_WIDTH (DATA_WIDTH_DEF)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one request beat, after a random number of idle cycles, and hold
  // it until the block takes it. Signals sampled right after the edge still
  // carry their pre-edge values, so full here is what the block saw.
  task automatic send_item(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    request <= r;
    do @(posedge clk); while (full);
    shadow.note_request(r);
  endtask

  // Sender pauses until every owed result beat has been popped.
  task automatic await_drain();
    push <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  function automatic req_t mk(logic [2:0] func, logic [5:0] position,
                              logic signed [31:0] value);
    req_t r;
    r.func       = func;
    r.position   = position;
    r.item_value = value;
    return r;
  endfunction

  // extremes show up often enough to matter
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return 32'shffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // An out-of-range position above hi, or zero.
  function automatic logic [5:0] bad_position(int hi);
    if ($urandom_range(0, 2) == 0 || hi >= 63) return '0;
    return 6'($urandom_range(hi + 1, 63));
  endfunction

  // Random request shaped by the current list length: mostly valid
  // positions, some out of range, a few unused codes and reads.
  // fill_pct steers inserts against deletes so the list swings between
  // empty and full.
  function automatic req_t make_request(int fill_pct);
    req_t r;
    int   n;
    int   pick;
    n            = shadow.word_count();
    r.item_value = rand_word();
    r.position   = 6'($urandom_range(0, 63));
    pick         = $urandom_range(0, 99);
    if (pick < 3) begin
      r.func = FN_UNUSED;
    end else if (pick < 13) begin
      r.func = FN_READ;
    end else if ($urandom_range(0, 99) < fill_pct) begin
      case ($urandom_range(0, 2))
        0:       r.func = FN_INS_FRONT;
        1:       r.func = FN_INS_BACK;
        default: begin
          r.func = FN_INS_POS;
          if ($urandom_range(0, 99) < 80) r.position = 6'($urandom_range(1, n + 1));
          else r.position = bad_position(n + 1);
        end
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       r.func = FN_DEL_FRONT;
        1:       r.func = FN_DEL_BACK;
        default: begin
          r.func = FN_DEL_POS;
          if ($urandom_range(0, 99) < 80)
            r.position = 6'($urandom_range(1, (n > 0) ? n : 1));
          else r.position = bad_position(n);
        end
      endcase
    end
    return r;
  endfunction

  // One random phase. Unused codes are sent but not counted. The fill bias
  // flips every 50 counted items; 50 at high bias is enough to hit full.
  task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
    int   done;
    req_t r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    done           = 0;
    while (done < n_items) begin
      r = make_request(((done / 50) % 2 == 0) ? 92 : 20);
      send_item(r);
      if (r.func != FN_UNUSED) done++;
    end
    await_drain();
  endtask

  // Result sink: checks each popped beat, then picks the next pop. A hold
  // request parks pop low for HOLD_CYCLES, counted here.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) shadow.check_result(result);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any beat on either side restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : main_seq
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-list answers, bad positions on both sides, extreme
    // words, positional inserts at front / middle / back, delete of the
    // last element by position, and an ignored unused code.
    send_item(mk(FN_READ,      6'd0,  '0));
    send_item(mk(FN_DEL_FRONT, 6'd0,  '0));
    send_item(mk(FN_DEL_BACK,  6'd0,  '0));
    send_item(mk(FN_DEL_POS,   6'd1,  '0));
    send_item(mk(FN_DEL_POS,   6'd0,  '0));
    send_item(mk(FN_DEL_POS,   6'd2,  '0));
    send_item(mk(FN_INS_POS,   6'd0,  32'sh1234_5678));
    send_item(mk(FN_INS_POS,   6'd2,  32'sh1234_5678));
    send_item(mk(FN_INS_POS,   6'd1,  32'sh8000_0000));
    send_item(mk(FN_INS_BACK,  6'd0,  32'sh7fff_ffff));
    send_item(mk(FN_INS_FRONT, 6'd0,  32'shffff_ffff));
    send_item(mk(FN_INS_POS,   6'd2,  32'sh0000_0000));
    send_item(mk(FN_INS_POS,   6'd5,  32'sh5555_5555));
    send_item(mk(FN_INS_POS,   6'd7,  32'sh0bad_0bad));
    send_item(mk(FN_READ,      6'd0,  '0));
    send_item(mk(FN_DEL_POS,   6'd3,  '0));
    send_item(mk(FN_DEL_POS,   6'd63, '0));
    send_item(mk(FN_DEL_POS,   6'd4,  '0));
    send_item(mk(FN_UNUSED,    6'd63, 32'shffff_ffff));
    send_item(mk(FN_INS_POS,   6'd33, 32'shaaaa_aaaa));
    send_item(mk(FN_DEL_FRONT, 6'd0,  '0));
    send_item(mk(FN_DEL_BACK,  6'd0,  '0));
    send_item(mk(FN_READ,      6'd0,  '0));
    await_drain();

    run_phase(ITEMS_PER_PH, 0,  0);
    run_phase(ITEMS_PER_PH, 87, 0);
    run_phase(ITEMS_PER_PH, 0,  87);
    run_phase(ITEMS_PER_PH, 31, 31);

    // Back-pressure: receiver parks pop while requests keep coming, so the
    // queues fill and full rises; then the sender waits out the drain.
    hold_request = 1'b1;
    run_phase(24, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.pending() != 0)
      shadow.flag($sformatf("%0d result beats never arrived", shadow.pending()));

    if (shadow.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
